@@ rtl/isfp_pkg.sv @@
// ----------------------------------------------------------------------------
// isfp_pkg: shared types and constants of the IMU serial frame parser
// Frame layout codes, register indexes and the job record that the
// classifier front hands to the scaling back.
// ----------------------------------------------------------------------------
package isfp_pkg;

    // Frame layout
    localparam int FRAME_BYTES = 11;
    localparam int WIN_TAPS    = FRAME_BYTES - 1;

    // Header and type codes
    localparam logic [7:0] HDR_SYNC   = 8'h55;
    localparam logic [7:0] HDR_MASK   = 8'h50;
    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_GYRO  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    // Configuration registers
    localparam int SCALE_W = 12;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_FS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_FS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_FS = 2'd2;
    localparam logic [SCALE_W-1:0] RST_ACCEL_FS = 12'd16;
    localparam logic [SCALE_W-1:0] RST_GYRO_FS  = 12'd2000;
    localparam logic [SCALE_W-1:0] RST_ANGLE_FS = 12'd180;

    // Sample words
    localparam int RAW_W  = 16;
    localparam int AXIS_W = 28;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_GYRO  = 2'd1,
        KIND_ANGLE = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic [SCALE_W-1:0]        scale;
        logic signed [RAW_W-1:0]   raw_x;
        logic signed [RAW_W-1:0]   raw_y;
        logic signed [RAW_W-1:0]   raw_z;
    } t_job;

endpackage

@@ rtl/imu_serial_frame_parser.sv @@
// ----------------------------------------------------------------------------
// imu_serial_frame_parser: 11-byte IMU frame parser with fixed-point scaling
// Receives one serial byte per transfer, finds frames that start with 0x55
// and a type byte with bits 0x50 set, and emits scaled three-axis samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_rx_valid / o_rx_stall / i_rx_byte) moves one received
//   byte per transfer. Output channel (o_sample_valid / i_sample_stall)
//   moves one sample per transfer: kind (0 accel, 1 gyro, 2 angle) and three
//   28-bit signed axis values, raw word times full scale in units of 2^-15.
//   Frames whose header check fails slide by one byte to resync; good frames
//   of other types are consumed without a sample.
//   Throughput: one byte per cycle while o_rx_stall is low. The window
//   shifts on each accepted byte, and a sample can leave the output
//   register every cycle while i_sample_stall is low. Path: the last
//   byte of a frame writes its job into the queue, and the job then loads
//   the multiplier output register unless an older sample is stalled.
//   Stall: a stalled sample holds in the output register; further jobs wait
//   in a QUEUE_DEPTH-entry queue, and o_rx_stall rises only when that queue
//   is full.
//   Reset (i_rst_n low, synchronous) empties the window and queue and loads
//   the full scales 16, 2000 and 180. Write full scales through
//   i_cfg_we / i_cfg_addr / i_cfg_wdata while the block is idle;
//   index 3 is ignored.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser #(
    parameter int QUEUE_DEPTH = isfp_pkg::QUEUE_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [isfp_pkg::CFG_IDX_W-1:0]         i_cfg_addr,
    input  logic [isfp_pkg::SCALE_W-1:0]           i_cfg_wdata,
    input  logic                                   i_rx_valid,
    output logic                                   o_rx_stall,
    input  logic [7:0]                             i_rx_byte,
    output logic                                   o_sample_valid,
    input  logic                                   i_sample_stall,
    output logic [1:0]                             o_sample_kind,
    output logic signed [isfp_pkg::AXIS_W-1:0]     o_axis_x,
    output logic signed [isfp_pkg::AXIS_W-1:0]     o_axis_y,
    output logic signed [isfp_pkg::AXIS_W-1:0]     o_axis_z
);
    import isfp_pkg::*;

    logic  rx_accept;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;
    t_job  push_job;
    t_job  head_job;

    // Hold off the link only while the job queue has no room
    assign o_rx_stall = q_full;
    assign rx_accept  = i_rx_valid && !q_full;

    isfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (rx_accept),
        .i_byte      (i_rx_byte),
        .o_push      (push),
        .o_job       (push_job)
    );

    isfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    isfp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head_job),
        .o_pop   (pop),
        .o_valid (o_sample_valid),
        .i_stall (i_sample_stall),
        .o_kind  (o_sample_kind),
        .o_x     (o_axis_x),
        .o_y     (o_axis_y),
        .o_z     (o_axis_z)
    );

`ifndef SYNTH
    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> !q_empty)
        else $error("link held off with an empty queue");
`endif

endmodule

@@ rtl/isfp_front.sv @@
// ----------------------------------------------------------------------------
// isfp_front: byte window and header classifier
// Shifts received bytes through a ten-byte window, checks the header when a
// full frame is present and pushes a scaling job for known sample types.
// ----------------------------------------------------------------------------
module isfp_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [isfp_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [isfp_pkg::SCALE_W-1:0]      i_cfg_wdata,
    input  logic                              i_accept,
    input  logic [7:0]                        i_byte,
    output logic                              o_push,
    output isfp_pkg::t_job                    o_job
);
    import isfp_pkg::*;

    localparam int HELD_W = $clog2(FRAME_BYTES);
    localparam logic [HELD_W-1:0] HELD_FULL = HELD_W'(WIN_TAPS);

    logic [7:0]          r_win [WIN_TAPS];
    logic [HELD_W-1:0]   r_held;
    logic [HELD_W-1:0]   n_held;
    logic [SCALE_W-1:0]  r_accel_fs;
    logic [SCALE_W-1:0]  r_gyro_fs;
    logic [SCALE_W-1:0]  r_angle_fs;

    logic frame_full;
    logic hdr_ok;
    logic type_known;

    assign frame_full = (r_held == HELD_FULL);
    assign hdr_ok     = (r_win[0] == HDR_SYNC) && ((r_win[1] & HDR_MASK) == HDR_MASK);

    always_comb begin
        type_known  = 1'b1;
        o_job.kind  = KIND_ACCEL;
        o_job.scale = r_accel_fs;
        case (r_win[1])
            TYPE_ACCEL: begin
                o_job.kind  = KIND_ACCEL;
                o_job.scale = r_accel_fs;
            end
            TYPE_GYRO: begin
                o_job.kind  = KIND_GYRO;
                o_job.scale = r_gyro_fs;
            end
            TYPE_ANGLE: begin
                o_job.kind  = KIND_ANGLE;
                o_job.scale = r_angle_fs;
            end
            default: begin
                type_known = 1'b0;
            end
        endcase
        o_job.raw_x = {r_win[3], r_win[2]};
        o_job.raw_y = {r_win[5], r_win[4]};
        o_job.raw_z = {r_win[7], r_win[6]};
    end

    // The incoming byte closes a frame when ten bytes are already held
    assign o_push = i_accept && frame_full && hdr_ok && type_known;

    always_comb begin
        n_held = r_held;
        if (i_accept) begin
            if (!frame_full) begin
                n_held = r_held + HELD_W'(1);
            end else if (!hdr_ok) begin
                n_held = HELD_FULL;
            end else begin
                n_held = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_accel_fs <= RST_ACCEL_FS;
            r_gyro_fs  <= RST_GYRO_FS;
            r_angle_fs <= RST_ANGLE_FS;
        end else begin
            r_held <= n_held;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ACCEL_FS: r_accel_fs <= i_cfg_wdata;
                    CFG_GYRO_FS:  r_gyro_fs  <= i_cfg_wdata;
                    CFG_ANGLE_FS: r_angle_fs <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Window advances on every accepted byte; the held count says which taps are real
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int i = 0; i < WIN_TAPS - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WIN_TAPS-1] <= i_byte;
        end
    end

`ifndef SYNTH
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HELD_FULL)
        else $error("held count past window size");

    a_push_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_held == '0))
        else $error("held count not cleared after a good frame");
`endif

endmodule

@@ rtl/isfp_queue.sv @@
// ----------------------------------------------------------------------------
// isfp_queue: short job queue between front and back
// Register-based FIFO of scaling jobs; head is shown while not empty.
// ----------------------------------------------------------------------------
module isfp_queue #(
    parameter int DEPTH = isfp_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  isfp_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output isfp_pkg::t_job  o_head
);
    import isfp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_job              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

@@ rtl/isfp_back.sv @@
// ----------------------------------------------------------------------------
// isfp_back: full-scale multipliers and output register
// Multiplies the three raw words of the queue head by the selected full
// scale and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module isfp_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_empty,
    input  isfp_pkg::t_job                         i_head,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [1:0]                             o_kind,
    output logic signed [isfp_pkg::AXIS_W-1:0]     o_x,
    output logic signed [isfp_pkg::AXIS_W-1:0]     o_y,
    output logic signed [isfp_pkg::AXIS_W-1:0]     o_z
);
    import isfp_pkg::*;

    localparam int PROD_W = RAW_W + SCALE_W + 1;

    logic                       r_valid;
    t_kind                      r_kind;
    logic signed [AXIS_W-1:0]   r_x;
    logic signed [AXIS_W-1:0]   r_y;
    logic signed [AXIS_W-1:0]   r_z;
    logic signed [SCALE_W:0]    scale_s;
    logic signed [PROD_W-1:0]   prod_x;
    logic signed [PROD_W-1:0]   prod_y;
    logic signed [PROD_W-1:0]   prod_z;
    logic                       load;

    assign scale_s = $signed({1'b0, i_head.scale});
    assign prod_x  = PROD_W'(i_head.raw_x * scale_s);
    assign prod_y  = PROD_W'(i_head.raw_y * scale_s);
    assign prod_z  = PROD_W'(i_head.raw_z * scale_s);

    // Load a new result when the output register is empty or being taken
    assign load  = !r_valid || !i_stall;
    assign o_pop = load && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_head.kind;
            r_x    <= prod_x[AXIS_W-1:0];
            r_y    <= prod_y[AXIS_W-1:0];
            r_z    <= prod_z[AXIS_W-1:0];
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

`ifndef SYNTH
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_kind != 2'd3))
        else $error("result carries an unused sample kind");
`endif

endmodule
